FILE: hw/rtl/hed_pkg.sv
// Shared types, constants and entity tables for the HTML entity decoder.
// No dependencies; every other file of the decoder except hed_ram refers to it by scoped names.
package hed_pkg;

    localparam int MAX_SCAN_DEF  = 32;
    localparam int MAX_LEAD_DEF  = 30;
    localparam int BUF_DEPTH_DEF = 64;
    localparam int ENT_COUNT     = 21;
    localparam int LEAD_W        = 5;
    localparam int PC_W          = 7;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic ws;
        logic amp;
        logic semi;
    } cls_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        cls_t       cls;
    } item_t;

    typedef struct packed {
        logic              run;
        logic              ient;
        logic [PC_W-1:0]   pc;
        logic [LEAD_W-1:0] lead;
    } stat_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        r.ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        r.amp  = (c == CH_AMP);
        r.semi = (c == CH_SEMI);
        return r;
    endfunction

    // names are right-justified: the last character sits in the lowest byte
    function automatic logic [47:0] ent_name(input logic [4:0] k);
        logic [47:0] nm;
        case (k)
            5'd0:    nm = "amp";
            5'd1:    nm = "lt";
            5'd2:    nm = "gt";
            5'd3:    nm = "quot";
            5'd4:    nm = "apos";
            5'd5:    nm = "nbsp";
            5'd6:    nm = "hellip";
            5'd7:    nm = "mdash";
            5'd8:    nm = "ndash";
            5'd9:    nm = "lsquo";
            5'd10:   nm = "rsquo";
            5'd11:   nm = "ldquo";
            5'd12:   nm = "rdquo";
            5'd13:   nm = "bull";
            5'd14:   nm = "copy";
            5'd15:   nm = "reg";
            5'd16:   nm = "trade";
            5'd17:   nm = "deg";
            5'd18:   nm = "frac12";
            5'd19:   nm = "frac14";
            5'd20:   nm = "frac34";
            default: nm = '0;
        endcase
        return nm;
    endfunction

    function automatic logic [2:0] ent_len(input logic [4:0] k);
        logic [2:0] n;
        case (k)
            5'd1, 5'd2:                                   n = 3'd2;
            5'd0, 5'd15, 5'd17:                           n = 3'd3;
            5'd3, 5'd4, 5'd5, 5'd13, 5'd14:               n = 3'd4;
            5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd16: n = 3'd5;
            5'd6, 5'd18, 5'd19, 5'd20:                    n = 3'd6;
            default:                                      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_char(input logic [4:0] k, input logic [2:0] i);
        logic [47:0] nm;
        logic [2:0]  n;
        logic [2:0]  sh;
        nm = ent_name(k);
        n  = ent_len(k);
        sh = n - 3'd1 - i;
        if (i >= n) begin
            return 8'h00;
        end
        return nm[{sh, 3'b000} +: 8];
    endfunction

    function automatic logic [1:0] ent_nb(input logic [4:0] k);
        logic [1:0] n;
        case (k)
            5'd6, 5'd7, 5'd8, 5'd13, 5'd16:       n = 2'd3;
            5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20: n = 2'd2;
            default:                              n = 2'd1;
        endcase
        return n;
    endfunction

    // byte 0 is sent first
    function automatic logic [2:0][7:0] ent_bytes(input logic [4:0] k);
        logic [2:0][7:0] b;
        b = '0;
        case (k)
            5'd0:         b[0] = 8'h26;
            5'd1:         b[0] = 8'h3C;
            5'd2:         b[0] = 8'h3E;
            5'd3:         b[0] = 8'h22;
            5'd4:         b[0] = 8'h27;
            5'd5:         b[0] = 8'h20;
            5'd6:         b = {8'hA6, 8'h80, 8'hE2};
            5'd7:         b = {8'h94, 8'h80, 8'hE2};
            5'd8:         b = {8'h93, 8'h80, 8'hE2};
            5'd9, 5'd10:  b[0] = 8'h27;
            5'd11, 5'd12: b[0] = 8'h22;
            5'd13:        b = {8'hA2, 8'h80, 8'hE2};
            5'd14:        b = {8'h00, 8'hA9, 8'hC2};
            5'd15:        b = {8'h00, 8'hAE, 8'hC2};
            5'd16:        b = {8'hA2, 8'h84, 8'hE2};
            5'd17:        b = {8'h00, 8'hB0, 8'hC2};
            5'd18:        b = {8'h00, 8'hBD, 8'hC2};
            5'd19:        b = {8'h00, 8'hBC, 8'hC2};
            5'd20:        b = {8'h00, 8'hBE, 8'hC2};
            default:      b = '0;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/hed_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module hed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/hed_front.sv
// Input side: accepts stream words, classifies each byte and holds them in a short queue.
// Depends on hed_pkg.
module hed_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] text_byte
    input  logic                s_tlast,
    output logic                q_valid,
    output hed_pkg::item_t      q_item,
    input  logic                q_pop
);

    hed_pkg::item_t slot_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ (q_pop && q_valid);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= '{data: s_tdata, last: s_tlast,
                                  cls: hed_pkg::classify(s_tdata)};
        end
    end

endmodule

FILE: hw/rtl/hed_back.sv
// Decode engine: entity scanning, replay of aborted entities, decode and output register.
// Depends on hed_pkg and hed_ram.
module hed_back #(
    parameter int MAX_SCAN       = hed_pkg::MAX_SCAN_DEF,
    parameter int MAX_LEAD_SPACE = hed_pkg::MAX_LEAD_DEF,
    parameter int BUF_DEPTH      = hed_pkg::BUF_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  hed_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output hed_pkg::stat_t      stat
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = hed_pkg::LEAD_W;

    typedef enum logic [5:0] {
        ST_RUN   = 6'b000001,
        ST_REPL  = 6'b000010,
        ST_SEQ   = 6'b000100,
        ST_VREQ  = 6'b001000,
        ST_VOUT  = 6'b010000,
        ST_VSEMI = 6'b100000
    } st_t;

    typedef enum logic [2:0] {
        N_SCAN = 3'b001,
        N_TAIL = 3'b010,
        N_BAD  = 3'b100
    } nst_t;

    st_t                      state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            pc_reg, pc_next;
    logic [AW-1:0]            rq_reg, rq_next;
    logic [LW-1:0]            lead_reg, lead_next;
    logic                     ient_reg, ient_next;
    logic                     endm_reg, endm_next;
    logic                     adv_reg, adv_next;
    logic [AW-1:0]            k_reg, k_next;
    logic [3:0][7:0]          seq_reg, seq_next;
    logic [2:0]               seqn_reg, seqn_next;
    logic [2:0]               seqi_reg, seqi_next;
    logic [5:0]               lnz_reg, lnz_next;
    logic                     gap_reg, gap_next;
    logic                     hash_reg, hash_next;
    logic                     hex_reg, hex_next;
    logic                     any_reg, any_next;
    nst_t                     nst_reg, nst_next;
    logic [31:0]              cp_reg, cp_next;
    logic [hed_pkg::ENT_COUNT-1:0] match_reg, match_next;
    logic                     hold_v_reg, hold_v_next;
    logic [7:0]               hold_reg, hold_next;
    logic                     o_v_reg, o_v_next;
    logic [7:0]               o_data_reg, o_data_next;
    logic                     o_end_reg, o_end_next;

    logic                     out_free;
    logic                     emit_v;
    logic [7:0]               emit_b;
    logic                     fin_v;
    logic                     endm_eff;
    logic                     step_go, step_repl;
    logic [7:0]               step_b;
    hed_pkg::cls_t            step_c;
    logic [AW-1:0]            body_i;
    logic                     wr_en, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic [7:0]               wr_data, rd_data;
    logic                     dig_ok;
    logic [3:0]               dig_v;
    logic                     num_ok, name_hit;
    logic [4:0]               name_k;
    logic [3:0][7:0]          dec_b;
    logic [2:0]               dec_n;
    logic [2:0][7:0]          eb;

    hed_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !o_v_reg || m_tready;
    assign body_i   = pc_reg - AW'(lead_reg);

    // decode of a finished body, from the scan trackers
    always_comb begin
        num_ok   = hash_reg && any_reg && (nst_reg != N_BAD);
        name_hit = 1'b0;
        name_k   = '0;
        for (int k = hed_pkg::ENT_COUNT - 1; k >= 0; k--) begin
            if (match_reg[k] && !hash_reg &&
                ({3'b000, hed_pkg::ent_len(5'(k))} == lnz_reg)) begin
                name_hit = 1'b1;
                name_k   = 5'(k);
            end
        end
        eb    = hed_pkg::ent_bytes(name_k);
        dec_b = '0;
        dec_n = 3'd1;
        if (!num_ok) begin
            dec_b[0] = eb[0];
            dec_b[1] = eb[1];
            dec_b[2] = eb[2];
            dec_n    = {1'b0, hed_pkg::ent_nb(name_k)};
        end else if (cp_reg == 32'h0000_00A0) begin
            dec_b[0] = hed_pkg::CH_SPACE;
        end else if (cp_reg > 32'h0010_FFFF ||
                     (cp_reg >= 32'h0000_D800 && cp_reg <= 32'h0000_DFFF)) begin
            dec_b[0] = hed_pkg::CH_QMARK;
        end else if (cp_reg <= 32'h0000_007F) begin
            dec_b[0] = cp_reg[7:0];
        end else if (cp_reg <= 32'h0000_07FF) begin
            dec_b[0] = 8'hC0 | {3'b000, cp_reg[10:6]};
            dec_b[1] = 8'h80 | {2'b00, cp_reg[5:0]};
            dec_n    = 3'd2;
        end else if (cp_reg <= 32'h0000_FFFF) begin
            dec_b[0] = 8'hE0 | {4'b0000, cp_reg[15:12]};
            dec_b[1] = 8'h80 | {2'b00, cp_reg[11:6]};
            dec_b[2] = 8'h80 | {2'b00, cp_reg[5:0]};
            dec_n    = 3'd3;
        end else begin
            dec_b[0] = 8'hF0 | {5'b00000, cp_reg[20:18]};
            dec_b[1] = 8'h80 | {2'b00, cp_reg[17:12]};
            dec_b[2] = 8'h80 | {2'b00, cp_reg[11:6]};
            dec_b[3] = 8'h80 | {2'b00, cp_reg[5:0]};
            dec_n    = 3'd4;
        end
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        pc_next     = pc_reg;
        rq_next     = rq_reg;
        lead_next   = lead_reg;
        ient_next   = ient_reg;
        endm_next   = endm_reg;
        adv_next    = adv_reg;
        k_next      = k_reg;
        seq_next    = seq_reg;
        seqn_next   = seqn_reg;
        seqi_next   = seqi_reg;
        lnz_next    = lnz_reg;
        gap_next    = gap_reg;
        hash_next   = hash_reg;
        hex_next    = hex_reg;
        any_next    = any_reg;
        nst_next    = nst_reg;
        cp_next     = cp_reg;
        match_next  = match_reg;
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        o_v_next    = o_v_reg && !m_tready;
        o_data_next = o_data_reg;
        o_end_next  = o_end_reg;
        emit_v      = 1'b0;
        emit_b      = '0;
        fin_v       = 1'b0;
        q_pop       = 1'b0;
        step_go     = 1'b0;
        step_repl   = 1'b0;
        step_b      = q_item.data;
        rd_en       = 1'b0;
        rd_addr     = head_reg + pc_reg;
        wr_en       = 1'b0;
        wr_addr     = head_reg + pc_reg;
        wr_data     = q_item.data;
        dig_ok      = 1'b0;
        dig_v       = '0;

        case (state_reg)
            ST_RUN: begin
                if (rq_reg != '0) begin
                    rd_en      = 1'b1;
                    state_next = ST_REPL;
                end else if (endm_reg) begin
                    if (out_free) begin
                        if (ient_reg) begin
                            // string ended inside an entity: replay the whole buffer
                            emit_v    = 1'b1;
                            emit_b    = hed_pkg::CH_AMP;
                            rq_next   = pc_reg;
                            pc_next   = '0;
                            lead_next = '0;
                            ient_next = 1'b0;
                        end else begin
                            fin_v     = hold_v_reg;
                            endm_next = 1'b0;
                        end
                    end
                end else if (q_valid && out_free) begin
                    step_go   = 1'b1;
                    q_pop     = 1'b1;
                    endm_next = q_item.last;
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    step_go    = 1'b1;
                    step_repl  = 1'b1;
                    step_b     = rd_data;
                    state_next = ST_RUN;
                end
            end
            ST_SEQ: begin
                if (out_free) begin
                    emit_v    = 1'b1;
                    emit_b    = seq_reg[seqi_reg[1:0]];
                    seqi_next = seqi_reg + 3'd1;
                    if (seqi_reg + 3'd1 == seqn_reg) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_VREQ: begin
                rd_en      = 1'b1;
                rd_addr    = head_reg + k_reg;
                state_next = ST_VOUT;
            end
            ST_VOUT: begin
                if (out_free) begin
                    emit_v     = 1'b1;
                    emit_b     = rd_data;
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == pc_reg) ? ST_VSEMI : ST_VREQ;
                end
            end
            ST_VSEMI: begin
                if (out_free) begin
                    emit_v     = 1'b1;
                    emit_b     = hed_pkg::CH_SEMI;
                    head_next  = head_reg + pc_reg + AW'(adv_reg);
                    pc_next    = '0;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        step_c = hed_pkg::classify(step_b);

        if (step_go) begin
            if (!ient_reg) begin
                if (step_c.amp) begin
                    ient_next  = 1'b1;
                    pc_next    = '0;
                    lead_next  = '0;
                    lnz_next   = '0;
                    gap_next   = 1'b0;
                    hash_next  = 1'b0;
                    hex_next   = 1'b0;
                    any_next   = 1'b0;
                    nst_next   = N_SCAN;
                    cp_next    = '0;
                    match_next = '1;
                end else begin
                    emit_v = 1'b1;
                    emit_b = step_b;
                end
                if (step_repl) begin
                    head_next = head_reg + 1'b1;
                    rq_next   = rq_reg - 1'b1;
                end
            end else if ((pc_reg == AW'(lead_reg)) && step_c.ws &&
                         (lead_reg < LW'(MAX_LEAD_SPACE)) &&
                         (pc_reg < AW'(BUF_DEPTH - 2))) begin
                wr_en     = !step_repl;
                pc_next   = pc_reg + 1'b1;
                lead_next = lead_reg + 1'b1;
                if (step_repl) begin
                    rq_next = rq_reg - 1'b1;
                end
            end else if (!((pc_reg == AW'(lead_reg)) && step_c.ws) && step_c.semi) begin
                // close the entity
                adv_next  = step_repl;
                ient_next = 1'b0;
                lead_next = '0;
                if (step_repl) begin
                    rq_next = rq_reg - 1'b1;
                end
                if (num_ok || name_hit) begin
                    seq_next   = dec_b;
                    seqn_next  = dec_n;
                    seqi_next  = '0;
                    head_next  = head_reg + pc_reg + AW'(step_repl);
                    pc_next    = '0;
                    state_next = ST_SEQ;
                end else begin
                    emit_v     = 1'b1;
                    emit_b     = hed_pkg::CH_AMP;
                    k_next     = '0;
                    state_next = (pc_reg == '0) ? ST_VSEMI : ST_VREQ;
                end
            end else if (!((pc_reg == AW'(lead_reg)) && step_c.ws) &&
                         (body_i < AW'(MAX_SCAN)) && (pc_reg < AW'(BUF_DEPTH - 2))) begin
                wr_en   = !step_repl;
                pc_next = pc_reg + 1'b1;
                if (step_repl) begin
                    rq_next = rq_reg - 1'b1;
                end
                if (step_c.ws) begin
                    gap_next = 1'b1;
                    if (nst_reg == N_SCAN) begin
                        nst_next = N_TAIL;
                    end
                end else begin
                    lnz_next = 6'(body_i) + 6'd1;
                    gap_next = 1'b0;
                    for (int k = 0; k < hed_pkg::ENT_COUNT; k++) begin
                        if (gap_reg || (body_i >= AW'(6)) ||
                            ({1'b0, body_i[2:0]} >= {1'b0, hed_pkg::ent_len(5'(k))}) ||
                            (hed_pkg::ent_char(5'(k), body_i[2:0]) != step_b)) begin
                            match_next[k] = 1'b0;
                        end
                    end
                    if (step_b >= 8'h30 && step_b <= 8'h39) begin
                        dig_ok = 1'b1;
                        dig_v  = step_b[3:0];
                    end else if (hex_reg && step_b >= 8'h61 && step_b <= 8'h66) begin
                        dig_ok = 1'b1;
                        dig_v  = step_b[3:0] + 4'd9;
                    end else if (hex_reg && step_b >= 8'h41 && step_b <= 8'h46) begin
                        dig_ok = 1'b1;
                        dig_v  = step_b[3:0] + 4'd9;
                    end
                    if (body_i == '0) begin
                        hash_next = (step_b == hed_pkg::CH_HASH);
                    end else if ((body_i == AW'(1)) && (nst_reg == N_SCAN) &&
                                 (step_b == 8'h78 || step_b == 8'h58)) begin
                        hex_next = 1'b1;
                    end else if ((nst_reg == N_SCAN) && dig_ok) begin
                        any_next = 1'b1;
                        cp_next  = hex_reg ? ({cp_reg[27:0], 4'b0000} + {28'd0, dig_v})
                                           : ({cp_reg[28:0], 3'b000} + {cp_reg[30:0], 1'b0}
                                              + {28'd0, dig_v});
                    end else begin
                        nst_next = N_BAD;
                    end
                end
            end else begin
                // abort: send '&' and feed the buffer back, then this byte
                emit_v    = 1'b1;
                emit_b    = hed_pkg::CH_AMP;
                ient_next = 1'b0;
                pc_next   = '0;
                lead_next = '0;
                if (step_repl) begin
                    rq_next = pc_reg + rq_reg;
                end else begin
                    wr_en   = 1'b1;
                    rq_next = pc_reg + 1'b1;
                end
            end
        end

        // output: during an end-marked string keep one byte back to tag the last
        endm_eff = endm_reg || (q_pop && q_item.last);
        if (fin_v) begin
            o_v_next    = 1'b1;
            o_data_next = hold_reg;
            o_end_next  = 1'b1;
            hold_v_next = 1'b0;
        end else if (emit_v) begin
            if (endm_eff) begin
                if (hold_v_reg) begin
                    o_v_next    = 1'b1;
                    o_data_next = hold_reg;
                    o_end_next  = 1'b0;
                end
                hold_next   = emit_b;
                hold_v_next = 1'b1;
            end else begin
                o_v_next    = 1'b1;
                o_data_next = emit_b;
                o_end_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_RUN;
            head_reg   <= '0;
            pc_reg     <= '0;
            rq_reg     <= '0;
            lead_reg   <= '0;
            ient_reg   <= 1'b0;
            endm_reg   <= 1'b0;
            hold_v_reg <= 1'b0;
            o_v_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            pc_reg     <= pc_next;
            rq_reg     <= rq_next;
            lead_reg   <= lead_next;
            ient_reg   <= ient_next;
            endm_reg   <= endm_next;
            hold_v_reg <= hold_v_next;
            o_v_reg    <= o_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        adv_reg    <= adv_next;
        k_reg      <= k_next;
        seq_reg    <= seq_next;
        seqn_reg   <= seqn_next;
        seqi_reg   <= seqi_next;
        lnz_reg    <= lnz_next;
        gap_reg    <= gap_next;
        hash_reg   <= hash_next;
        hex_reg    <= hex_next;
        any_reg    <= any_next;
        nst_reg    <= nst_next;
        cp_reg     <= cp_next;
        match_reg  <= match_next;
        hold_reg   <= hold_next;
        o_data_reg <= o_data_next;
        o_end_reg  <= o_end_next;
    end

    assign m_tvalid  = o_v_reg;
    assign m_tdata   = o_data_reg;
    assign m_tlast   = o_end_reg;
    assign stat.run  = (state_reg == ST_RUN);
    assign stat.ient = ient_reg;
    assign stat.pc   = hed_pkg::PC_W'(pc_reg);
    assign stat.lead = lead_reg;

endmodule

FILE: hw/rtl/html_entity_decoder.sv
// Top level of the HTML entity decoder (text bytes in, UTF-8 bytes out).
// Depends on hed_pkg, hed_front, hed_back and hed_ram.
//
//  channel  | dir | tdata             | tlast
//  ---------+-----+-------------------+-----------
//  s_       | in  | [7:0] text_byte   | text_end
//  m_       | out | [7:0] result_byte | result_end
//
// Plain bytes pass at one per cycle while the output is not stalled. Every byte fed back
// from the entity buffer takes a read of the buffer RAM and then a decode step, and an unknown
// entity is written out with a read and an output step per buffered byte for the same reason.
// A decoded entity emits one to four bytes at one per cycle while the output is not stalled.
// Reset: aresetn low for one clock; no clearing pass.
// Either side may stall on its own: a two-word input queue and an output register part them.
module html_entity_decoder #(
    parameter int MAX_SCAN       = hed_pkg::MAX_SCAN_DEF,
    parameter int MAX_LEAD_SPACE = hed_pkg::MAX_LEAD_DEF,
    parameter int BUF_DEPTH      = hed_pkg::BUF_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] result_byte
    output logic       m_tlast
);

    logic           q_valid;
    logic           q_pop;
    hed_pkg::item_t q_item;
    hed_pkg::stat_t stat;

    hed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    hed_back #(
        .MAX_SCAN       (MAX_SCAN),
        .MAX_LEAD_SPACE (MAX_LEAD_SPACE),
        .BUF_DEPTH      (BUF_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    a_pc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pc <= hed_pkg::PC_W'(BUF_DEPTH - 2))
        else $error("entity buffer count over limit");

    a_lead_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.lead <= hed_pkg::LEAD_W'(MAX_LEAD_SPACE)) &&
        ({2'b00, stat.lead} <= stat.pc))
        else $error("leading whitespace count inconsistent");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.run && !stat.ient) |-> (stat.pc == '0))
        else $error("pending bytes left outside an entity");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: dv/html_entity_decoder_tb.sv
// Testbench for html_entity_decoder: drives text bytes with random gaps and
// back-pressure, predicts the decoded UTF-8 stream in SystemVerilog and
// checks every output word. Depends on hed_pkg and the decoder RTL.
module html_entity_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_LIMIT  = hed_pkg::MAX_SCAN_DEF;
    localparam int LEAD_LIMIT  = hed_pkg::MAX_LEAD_DEF;
    localparam int BUF_SIZE    = hed_pkg::BUF_DEPTH_DEF;
    localparam int STEP_CAP    = 64;
    localparam int REPLAY_CAP  = BUF_SIZE + 4;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_word_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] text_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] result_byte
    logic       m_tlast;

    html_entity_decoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // decoder state mirrored by the predictor
    logic [7:0] ent_buf [BUF_SIZE];
    int         ent_cnt;
    int         ent_lead;
    bit         ent_open;
    int         step_words;

    out_word_t  decoded_q[$];
    int         errors;
    int         bytes_in;
    int         bytes_out;
    int         snd_idle_pct;
    int         rcv_idle_pct;
    int         rcv_hold;
    int         quiet_cycles;

    string      ent_names [21] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "hellip",
        "mdash", "ndash", "lsquo", "rsquo", "ldquo", "rdquo", "bull", "copy", "reg",
        "trade", "deg", "frac12", "frac14", "frac34"};
    logic [23:0] ent_utf8 [21] = '{24'h26, 24'h3C, 24'h3E, 24'h22, 24'h27, 24'h20,
        24'hE280A6, 24'hE28094, 24'hE28093, 24'h27, 24'h27, 24'h22, 24'h22, 24'hE280A2,
        24'hC2A9, 24'hC2AE, 24'hE284A2, 24'hC2B0, 24'hC2BD, 24'hC2BC, 24'hC2BE};
    int          ent_nbytes [21] = '{1, 1, 1, 1, 1, 1, 3, 3, 3, 1, 1, 1, 1, 3, 2, 2, 3, 2,
        2, 2, 2};

    function automatic bit is_space(logic [7:0] c);
        return c == hed_pkg::CH_SPACE || c == hed_pkg::CH_TAB ||
               c == hed_pkg::CH_CR || c == hed_pkg::CH_LF;
    endfunction

    function automatic void push_word(logic [7:0] b);
        out_word_t w;
        if (step_words < STEP_CAP) begin
            w.data = b;
            w.last = 1'b0;
            decoded_q.push_back(w);
            step_words++;
        end
    endfunction

    function automatic void push_code_point(logic [31:0] cp);
        if (cp == 32'hA0) begin
            push_word(hed_pkg::CH_SPACE);
        end else if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
            push_word(hed_pkg::CH_QMARK);
        end else if (cp <= 32'h7F) begin
            push_word(cp[7:0]);
        end else if (cp <= 32'h7FF) begin
            push_word(8'hC0 | cp[10:6]);
            push_word(8'h80 | cp[5:0]);
        end else if (cp <= 32'hFFFF) begin
            push_word(8'hE0 | cp[15:12]);
            push_word(8'h80 | cp[11:6]);
            push_word(8'h80 | cp[5:0]);
        end else begin
            push_word(8'hF0 | cp[20:18]);
            push_word(8'h80 | cp[17:12]);
            push_word(8'h80 | cp[11:6]);
            push_word(8'h80 | cp[5:0]);
        end
    endfunction

    function automatic void close_entity();
        ent_open = 0;
        ent_cnt  = 0;
        ent_lead = 0;
    endfunction

    // decode the body once ';' has arrived
    function automatic void decode_body();
        int          len;
        int          t;
        int          base;
        bit          hex;
        bit          any;
        bit          done;
        bit          same;
        logic [31:0] cp;
        logic [7:0]  c;
        base = ent_lead;
        len  = ent_cnt - ent_lead;
        done = 0;
        while (len > 0 && is_space(ent_buf[base + len - 1])) len--;
        if (len > 0 && ent_buf[base] == hed_pkg::CH_HASH) begin
            t   = 1;
            hex = 0;
            any = 0;
            cp  = '0;
            if (t < len && (ent_buf[base + t] == "x" || ent_buf[base + t] == "X")) begin
                hex = 1;
                t++;
            end
            for (; t < len; t++) begin
                c = ent_buf[base + t];
                if (c >= "0" && c <= "9")
                    cp = hex ? (cp << 4) + (c - "0") : cp * 10 + (c - "0");
                else if (hex && c >= "a" && c <= "f")
                    cp = (cp << 4) + (c - "a" + 10);
                else if (hex && c >= "A" && c <= "F")
                    cp = (cp << 4) + (c - "A" + 10);
                else
                    break;
                any = 1;
            end
            while (t < len && is_space(ent_buf[base + t])) t++;
            if (any && t == len) begin
                push_code_point(cp);
                done = 1;
            end
        end else begin
            for (int k = 0; k < 21 && !done; k++) begin
                if (ent_names[k].len() == len) begin
                    same = 1;
                    for (int i = 0; i < len; i++)
                        if (ent_names[k][i] != ent_buf[base + i]) same = 0;
                    if (same) begin
                        for (int m = ent_nbytes[k] - 1; m >= 0; m--)
                            push_word(ent_utf8[k][8*m +: 8]);
                        done = 1;
                    end
                end
            end
        end
        if (!done) begin
            push_word(hed_pkg::CH_AMP);
            for (int k = 0; k < ent_cnt; k++) push_word(ent_buf[k]);
            push_word(hed_pkg::CH_SEMI);
        end
        close_entity();
    endfunction

    // push bytes through the decoder model; an abort replays the buffer ahead of them
    function automatic void feed_bytes(logic [7:0] pending[$]);
        logic [7:0] b;
        logic [7:0] replay[$];
        bit         abort_now;
        while (pending.size() > 0) begin
            b = pending[0];
            abort_now = 0;
            if (!ent_open) begin
                if (b == hed_pkg::CH_AMP) begin
                    ent_open = 1;
                    ent_cnt  = 0;
                    ent_lead = 0;
                end else begin
                    push_word(b);
                end
            end else if (ent_cnt == ent_lead && is_space(b)) begin
                if (ent_lead < LEAD_LIMIT && ent_cnt < BUF_SIZE - 2) begin
                    ent_buf[ent_cnt] = b;
                    ent_cnt++;
                    ent_lead++;
                end else begin
                    abort_now = 1;
                end
            end else if (b == hed_pkg::CH_SEMI) begin
                decode_body();
            end else if (ent_cnt - ent_lead < SCAN_LIMIT && ent_cnt < BUF_SIZE - 2) begin
                ent_buf[ent_cnt] = b;
                ent_cnt++;
            end else begin
                abort_now = 1;
            end
            if (abort_now) begin
                push_word(hed_pkg::CH_AMP);
                replay = {};
                for (int k = 0; k < ent_cnt && replay.size() < REPLAY_CAP; k++)
                    replay.push_back(ent_buf[k]);
                foreach (pending[k])
                    if (replay.size() < REPLAY_CAP) replay.push_back(pending[k]);
                pending = replay;
                close_entity();
            end else begin
                void'(pending.pop_front());
            end
        end
    endfunction

    function automatic void predict_text(logic [7:0] b, logic text_end);
        logic [7:0] one[$];
        logic [7:0] held[$];
        int         first_word;
        first_word = decoded_q.size();
        step_words = 0;
        one = {b};
        feed_bytes(one);
        if (text_end) begin
            while (ent_open) begin
                held = {};
                for (int k = 0; k < ent_cnt; k++) held.push_back(ent_buf[k]);
                push_word(hed_pkg::CH_AMP);
                close_entity();
                feed_bytes(held);
            end
            if (decoded_q.size() > first_word) decoded_q[$].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // one text byte; tvalid stays high across back-to-back words
    task automatic send_text(logic [7:0] b, logic text_end);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= text_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_text(b, text_end);
        bytes_in++;
    endtask

    task automatic send_string(string s, bit text_end);
        for (int i = 0; i < s.len(); i++)
            send_text(s[i], text_end && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (decoded_q.size() > 0) @(posedge aclk);
    endtask

    function automatic string random_body();
        string s;
        int    pick;
        pick = $urandom_range(5);
        case (pick)
            0: s = $sformatf("#%0d", $urandom_range(0, 1200000));
            1: s = $sformatf("#x%0h", $urandom_range(0, 32'h11FFFF));
            2: s = $sformatf("#X%0H ", $urandom());
            3: s = "bogus";
            default: s = ent_names[$urandom_range(20)];
        endcase
        if ($urandom_range(3) == 0) s = {" \t", s, "\n"};
        return s;
    endfunction

    task automatic test_directed();
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_string("a&amp;&#65;&#x20AC;&#XD800;&#160;&#1114112;", 1'b0);
        send_string("&#x1F600;&;& ;&foo;&#4294967297;", 1'b1);
        send_string("&lt", 1'b1);
        send_string("& \t", 1'b1);
        wait_drained();
    endtask

    task automatic test_named_entities();
        for (int k = 0; k < 21; k++) send_string({"&", ent_names[k], ";"}, k == 20);
        wait_drained();
    endtask

    task automatic test_overflow();
        string s;
        s = "&";
        repeat (LEAD_LIMIT + 1) s = {s, " "};
        send_string({s, "x"}, 1'b1);
        s = "& ";
        repeat (SCAN_LIMIT + 1) s = {s, "q"};
        send_string({s, ";"}, 1'b1);
        s = "&";
        repeat (LEAD_LIMIT) s = {s, "\t"};
        repeat (SCAN_LIMIT) s = {s, "&"};
        send_string({s, "z;"}, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(3) == 0) begin
                send_text($urandom_range(255), $urandom_range(7) == 0);
                sent++;
            end else begin
                send_string({"&", random_body(), ($urandom_range(5) == 0) ? "" : ";"},
                    $urandom_range(4) == 0);
                sent += 6;
            end
        end
        send_text("!", 1'b1);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        rcv_hold = 300;
        send_string("&hellip;&frac12;&#x10FFFF;&copy;plain&bull;&trade;", 1'b1);
        wait_drained();
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // output side: check, stall and watch for a hang
    initial begin
        out_word_t w;
        m_tready     = 1'b0;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                bytes_out++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected word", {m_tlast, m_tdata}, '0);
                end else begin
                    w = decoded_q.pop_front();
                    if (m_tdata !== w.data) report_mismatch("result_byte", m_tdata, w.data);
                    if (m_tlast !== w.last) report_mismatch("result_end", m_tlast, w.last);
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
                    (!s_tvalid && decoded_q.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("html_entity_decoder_tb NOT OK");
                $finish;
            end
            if (rcv_hold > 0) begin
                m_tready <= 1'b0;
                rcv_hold--;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        errors = 0; bytes_in = 0; bytes_out = 0; rcv_hold = 0;
        snd_idle_pct = 10;
        rcv_idle_pct = 55;
        close_entity();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_named_entities();
        test_overflow();
        test_random(60);
        snd_idle_pct = 55;
        rcv_idle_pct = 10;
        test_random(50);
        test_back_pressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(50);
        repeat (100) @(posedge aclk);
        $display("sent %0d text bytes and checked %0d decoded bytes across named, numeric,",
            bytes_in, bytes_out);
        $display("unknown and aborted entities under random gaps and long output stalls");
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("html_entity_decoder_tb OK");
        end else begin
            $display("%0d mismatches, %0d words never seen", errors, decoded_q.size());
            $display("html_entity_decoder_tb NOT OK");
        end
        $finish;
    end
endmodule
